// ===== design/awc_pkg.sv =====
package awc_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int FRAC_BITS    = 20;
  localparam int WORK_FRAC    = 20;

  // Input alignment into the working format
  localparam int DN = (FRAC_BITS > WORK_FRAC) ? FRAC_BITS - WORK_FRAC : 0;
  localparam int UP = (WORK_FRAC > FRAC_BITS) ? WORK_FRAC - FRAC_BITS : 0;
  localparam int AW = SAMPLE_WIDTH - FRAC_BITS + WORK_FRAC;
  // Output rounding shift: Q(20+12) down to FRAC_BITS
  localparam int OS = WORK_FRAC + 12 - FRAC_BITS;

  localparam int ZW   = WORK_FRAC + 1;
  localparam int QW   = 22;
  localparam int DIVW = 44;
  localparam int DVDW = 64;
  localparam int MW   = ZW + 16;

  localparam longint unsigned WONE        = 64'd1 << WORK_FRAC;
  localparam longint unsigned TWO_THIRDS  = 64'd699051;
  localparam longint unsigned TWO_OVER_PI = 64'd667544;
  localparam longint unsigned HALF_PI     = 64'd1647099;

  localparam logic signed [23:0] AT1 = 24'sd1048435;
  localparam logic signed [23:0] AT3 = 24'sd346344;
  localparam logic signed [23:0] AT5 = 24'sd188892;
  localparam logic signed [23:0] AT7 = 24'sd89268;
  localparam logic signed [23:0] AT9 = 24'sd21847;

  typedef enum logic [1:0] {
    MODE_SOFT  = 2'd0,
    MODE_CUBIC = 2'd1,
    MODE_TANH  = 2'd2,
    MODE_ATAN  = 2'd3
  } mode_t;

  typedef enum logic {
    CFG_MODE = 1'b0,
    CFG_GAIN = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic          neg;
    logic          big;
    logic [ZW-1:0] zsm;
    logic [ZW-1:0] ycub;
  } side_t;

  typedef struct packed {
    logic [DIVW-1:0] rem;
    logic [QW-1:0]   low;
    logic [DIVW-1:0] dsr;
    logic [QW-1:0]   quo;
  } div_t;

  // Q20 multiply, truncated toward zero
  function automatic logic signed [23:0] smul_tz(input logic signed [23:0] p,
                                                 input logic [ZW-1:0] m);
    logic [23:0] mag;
    logic [44:0] prod;
    logic [23:0] r;
    mag  = p[23] ? 24'(-p) : 24'(p);
    prod = 45'(mag) * 45'(m);
    r    = 24'(prod >> WORK_FRAC);
    return p[23] ? -$signed(r) : $signed(r);
  endfunction

endpackage

// ===== design/audio_waveshape_clipper.sv =====
// Memoryless audio waveshaper: one signed Q3.20 sample in, one shaped and
// saturated sample out, with the curve picked by the mode register (soft,
// cubic hard clip, tanh, arctangent) and scaled by the Q4.12 gain register.
// Throughput is one transaction per clock while out_ready holds; there are 5
// front stages for magnitude, the cubic curve and the tanh Pade polynomials,
// 22 restoring divider cells (one quotient bit per cell, shared by soft, tanh
// and arctangent), and 9 back stages for the arctangent polynomial, gain,
// rounding and the output register. The whole pipeline advances whenever the
// output register is empty or being taken, so in_ready follows out_ready. Write
// mode and gain only while no transaction is in flight.
module audio_waveshape_clipper import awc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SAMPLE_WIDTH-1:0] out_sample_out,
  output logic                    out_saturated,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [0:0]              cfg_index,
  input  logic [15:0]             cfg_data
);

  localparam int NCELL = QW;

  mode_t       mode_r;
  logic [15:0] gain_r;
  logic        adv;

  logic  cv   [NCELL+1];
  div_t  cdiv [NCELL+1];
  side_t cside[NCELL+1];

  // Hold everything while a finished result waits and is not taken
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SOFT;
      gain_r <= 16'd4096;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MODE) begin
        mode_r <= mode_t'(cfg_data[1:0]);
      end else begin
        gain_r <= cfg_data;
      end
    end
  end

  awc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vi     (in_valid),
    .sample (in_sample_in),
    .mode   (mode_r),
    .vo     (cv[0]),
    .div_o  (cdiv[0]),
    .side_o (cside[0])
  );

  // Row of divider cells, one quotient bit each
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    awc_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vi     (cv[i]),
      .div_i  (cdiv[i]),
      .side_i (cside[i]),
      .vo     (cv[i+1]),
      .div_o  (cdiv[i+1]),
      .side_o (cside[i+1])
    );
  end

  awc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .vi         (cv[NCELL]),
    .quo        (cdiv[NCELL].quo),
    .side       (cside[NCELL]),
    .mode       (mode_r),
    .gain       (gain_r),
    .vo         (out_valid),
    .sample_out (out_sample_out),
    .saturated  (out_saturated)
  );

endmodule

// ===== design/awc_front.sv =====
module awc_front import awc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vi,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  mode_t                   mode,
  output logic                    vo,
  output div_t                    div_o,
  output side_t                   side_o
);

  logic [SAMPLE_WIDTH-1:0] mag;
  logic [AW-1:0]           a_in;
  logic [22:0]             ac_c;
  logic [45:0]             sq;
  logic [28:0]             p1;
  logic [31:0]             q1;
  logic [53:0]             pp2;
  logic [56:0]             qq2;
  logic [47:0]             t3p;
  logic [59:0]             pp3;
  logic [62:0]             qq3;
  logic [40:0]             d3p;
  logic [62:0]             np;
  logic [DVDW-1:0]         dvd;
  logic [DIVW-1:0]         dsr;
  logic                    big;

  logic                    v_r [5];
  logic                    neg_r [5];
  logic [AW-1:0]           a_r [5];
  logic [22:0]             ac_r [1:3];
  logic [24:0]             u_r [1:2];
  logic [34:0]             p2_r;
  logic [37:0]             q2_r;
  logic [ZW-1:0]           t3_r;
  logic [39:0]             p3_r;
  logic [42:0]             q3_r [3:4];
  logic [ZW-1:0]           yc_r [3:4];
  logic [42:0]             num_r;

  assign mag  = sample[SAMPLE_WIDTH-1] ? (~sample + 1'b1) : sample;
  assign a_in = AW'(mag >> DN) << UP;
  assign ac_c = (64'(a_r[0]) > 5 * WONE) ? 23'(5 * WONE) : 23'(a_r[0]);
  assign sq   = 46'(ac_c) * 46'(ac_c);
  assign p1   = 29'(378 * WONE) + 29'(u_r[1]);
  assign q1   = 32'(3150 * WONE) + 32'(u_r[1]) * 32'd28;
  assign pp2  = 54'(u_r[1]) * 54'(p1);
  assign qq2  = 57'(u_r[1]) * 57'(q1);
  assign t3p  = 48'(u_r[1]) * 48'(ac_r[1]);
  assign pp3  = 60'(u_r[2]) * 60'(p2_r);
  assign qq3  = 63'(u_r[2]) * 63'(q2_r);
  assign d3p  = 41'(t3_r) * 41'(TWO_THIRDS);
  assign np   = 63'(ac_r[3]) * 63'(p3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 5; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vi;
      for (int k = 1; k < 5; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= sample[SAMPLE_WIDTH-1];
      a_r[0]   <= a_in;
      for (int k = 1; k < 5; k++) begin
        neg_r[k] <= neg_r[k-1];
        a_r[k]   <= a_r[k-1];
      end
      ac_r[1] <= ac_c;
      ac_r[2] <= ac_r[1];
      ac_r[3] <= ac_r[2];
      u_r[1]  <= 25'(sq >> WORK_FRAC);
      u_r[2]  <= u_r[1];
      p2_r    <= 35'(17325 * WONE) + 35'(pp2 >> WORK_FRAC);
      q2_r    <= 38'(62370 * WONE) + 38'(qq2 >> WORK_FRAC);
      t3_r    <= ZW'(t3p >> WORK_FRAC);
      p3_r    <= 40'(135135 * WONE) + 40'(pp3 >> WORK_FRAC);
      q3_r[3] <= 43'(135135 * WONE) + 43'(qq3 >> WORK_FRAC);
      q3_r[4] <= q3_r[3];
      // divide by three through the reciprocal; exact for these magnitudes
      yc_r[3] <= (64'(a_r[2]) > WONE) ? ZW'(TWO_THIRDS)
                                      : ZW'(ac_r[2]) - ZW'(d3p >> 21);
      yc_r[4] <= yc_r[3];
      num_r   <= 43'(np >> WORK_FRAC);
    end
  end

  assign big = 64'(a_r[4]) > WONE;

  always_comb begin
    dvd = '0;
    dsr = DIVW'(1);
    unique case (mode)
      MODE_SOFT: begin
        dvd = DVDW'(a_r[4]) << WORK_FRAC;
        dsr = DIVW'(a_r[4]) + DIVW'(WONE);
      end
      MODE_TANH: begin
        dvd = DVDW'(num_r) << WORK_FRAC;
        dsr = DIVW'(q3_r[4]);
      end
      MODE_ATAN: begin
        if (big) begin
          dvd = DVDW'(1) << (2 * WORK_FRAC);
          dsr = DIVW'(a_r[4]);
        end
      end
      default: begin
        dvd = '0;
        dsr = DIVW'(1);
      end
    endcase
  end

  assign vo          = v_r[4];
  assign div_o.rem   = DIVW'(dvd >> QW);
  assign div_o.low   = dvd[QW-1:0];
  assign div_o.dsr   = dsr;
  assign div_o.quo   = '0;
  assign side_o.neg  = neg_r[4];
  assign side_o.big  = big;
  assign side_o.zsm  = ZW'(a_r[4]);
  assign side_o.ycub = yc_r[4];

endmodule

// ===== design/awc_div_cell.sv =====
module awc_div_cell import awc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  vi,
  input  div_t  div_i,
  input  side_t side_i,
  output logic  vo,
  output div_t  div_o,
  output side_t side_o
);

  logic [DIVW:0] trial;
  logic          ge;
  logic          v_r;
  div_t          div_r;
  side_t         side_r;

  assign trial = {div_i.rem, div_i.low[QW-1]};
  assign ge    = trial >= {1'b0, div_i.dsr};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r.rem <= ge ? DIVW'(trial - {1'b0, div_i.dsr}) : trial[DIVW-1:0];
      div_r.low <= {div_i.low[QW-2:0], 1'b0};
      div_r.dsr <= div_i.dsr;
      div_r.quo <= {div_i.quo[QW-2:0], ge};
      side_r    <= side_i;
    end
  end

  assign vo     = v_r;
  assign div_o  = div_r;
  assign side_o = side_r;

endmodule

// ===== design/awc_back.sv =====
module awc_back import awc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vi,
  input  logic [QW-1:0]           quo,
  input  side_t                   side,
  input  mode_t                   mode,
  input  logic [15:0]             gain,
  output logic                    vo,
  output logic [SAMPLE_WIDTH-1:0] sample_out,
  output logic                    saturated
);

  logic [ZW-1:0]     z_c;
  logic [41:0]       zz;
  logic [ZW-1:0]     t_c;
  logic [40:0]       tp;
  logic [ZW-1:0]     yb_c;
  logic signed [23:0] pz;
  logic [ZW-1:0]     pc;
  logic [40:0]       rp;
  logic [MW-1:0]     mr;
  logic [MW-1:0]     lim;
  logic              sat;
  logic [MW-1:0]     mo;

  logic              v_r [5];
  logic              neg_r [5];
  logic              big_r [5];
  logic [ZW-1:0]     z_r [5];
  logic [ZW-1:0]     z2_r [5];
  logic [ZW-1:0]     yb_r [5];
  logic signed [23:0] p_r [1:4];
  logic              v6_r, v7_r, v8_r, vo_r;
  logic              neg6_r, neg7_r, neg8_r;
  logic [ZW-1:0]     r6_r, yb6_r, y7_r;
  logic [MW-1:0]     m8_r;
  logic [SAMPLE_WIDTH-1:0] so_r;
  logic              sat_r;

  assign z_c  = side.big ? quo[ZW-1:0] : side.zsm;
  assign zz   = 42'(z_c) * 42'(z_c);
  assign t_c  = (64'(quo) > WONE) ? ZW'(WONE) : ZW'(quo);
  assign tp   = 41'(t_c) * 41'(TWO_OVER_PI);

  always_comb begin
    case (mode)
      MODE_SOFT:  yb_c = ZW'(quo);
      MODE_CUBIC: yb_c = side.ycub;
      MODE_TANH:  yb_c = ZW'(tp >> WORK_FRAC);
      default:    yb_c = '0;
    endcase
  end

  assign pz  = smul_tz(p_r[4], z_r[4]);
  assign pc  = pz[23] ? '0 : ZW'(pz);
  assign rp  = 41'(r6_r) * 41'(TWO_OVER_PI);
  assign mr  = MW'((m8_r + (MW'(1) << (OS - 1))) >> OS);
  assign lim = neg8_r ? (MW'(1) << (SAMPLE_WIDTH - 1))
                      : (MW'(1) << (SAMPLE_WIDTH - 1)) - MW'(1);
  assign sat = mr > lim;
  assign mo  = sat ? lim : mr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 5; k++) v_r[k] <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= vi;
      for (int k = 1; k < 5; k++) v_r[k] <= v_r[k-1];
      v6_r <= v_r[4];
      v7_r <= v6_r;
      v8_r <= v7_r;
      vo_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= side.neg;
      big_r[0] <= side.big;
      z_r[0]   <= z_c;
      z2_r[0]  <= ZW'(zz >> WORK_FRAC);
      yb_r[0]  <= yb_c;
      for (int k = 1; k < 5; k++) begin
        neg_r[k] <= neg_r[k-1];
        big_r[k] <= big_r[k-1];
        z_r[k]   <= z_r[k-1];
        z2_r[k]  <= z2_r[k-1];
        yb_r[k]  <= yb_r[k-1];
      end
      // Horner steps of the odd arctangent polynomial in z squared
      p_r[1] <= smul_tz(AT9, z2_r[0]) - AT7;
      p_r[2] <= smul_tz(p_r[1], z2_r[1]) + AT5;
      p_r[3] <= smul_tz(p_r[2], z2_r[2]) - AT3;
      p_r[4] <= smul_tz(p_r[3], z2_r[3]) + AT1;
      neg6_r <= neg_r[4];
      yb6_r  <= yb_r[4];
      r6_r   <= big_r[4] ? ZW'(HALF_PI) - pc : pc;
      neg7_r <= neg6_r;
      y7_r   <= (mode == MODE_ATAN) ? ZW'(rp >> WORK_FRAC) : yb6_r;
      neg8_r <= neg7_r;
      m8_r   <= MW'(y7_r) * MW'(gain);
      so_r   <= neg8_r ? SAMPLE_WIDTH'(-mo) : SAMPLE_WIDTH'(mo);
      sat_r  <= sat;
    end
  end

  assign vo         = vo_r;
  assign sample_out = so_r;
  assign saturated  = sat_r;

endmodule

// ===== tb/sv/audio_waveshape_clipper_test.sv =====
`timescale 1ns / 100ps

module audio_waveshape_clipper_test;
  import awc_pkg::*;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    sat;
  } shaped_t;

  // Holds the register copy, the shaping predictor and the queue of samples
  // still owed by the pipeline.
  class shaper_scoreboard;
    mode_t       mode;
    logic [15:0] gain;
    shaped_t     pending[$];
    int          mismatches;

    function new();
      mode       = MODE_SOFT;
      gain       = 16'd4096;
      mismatches = 0;
    endfunction

    // Q20 multiply with the product magnitude truncated toward zero
    function longint q20_mul(longint x, longint y);
      longint unsigned mx, my, m;
      mx = x < 0 ? -x : x;
      my = y < 0 ? -y : y;
      m  = (mx * my) >> WORK_FRAC;
      return ((x < 0) != (y < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function longint unsigned atan_poly(longint unsigned z);
      longint z2, p;
      z2 = q20_mul(z, z);
      p  = 21847;
      p  = q20_mul(p, z2) - 89268;
      p  = q20_mul(p, z2) + 188892;
      p  = q20_mul(p, z2) - 346344;
      p  = q20_mul(p, z2) + 1048435;
      p  = q20_mul(p, z);
      return p < 0 ? 64'd0 : longint'(p);
    endfunction

    // Curve applied to the magnitude in Q20
    function longint unsigned curve(longint unsigned a);
      longint unsigned u, p, q, num, t, r;
      case (mode)
        MODE_SOFT: return (a << 20) / (a + WONE);
        MODE_CUBIC: begin
          if (a > WONE) return TWO_THIRDS;
          u = (a * a) >> 20;
          t = (u * a) >> 20;
          return a - t / 3;
        end
        MODE_TANH: begin
          if (a > 5 * WONE) a = 5 * WONE;
          u   = (a * a) >> 20;
          p   = 378 * WONE + ((u * WONE) >> 20);
          p   = 17325 * WONE + ((u * p) >> 20);
          p   = 135135 * WONE + ((u * p) >> 20);
          q   = 3150 * WONE + ((u * (28 * WONE)) >> 20);
          q   = 62370 * WONE + ((u * q) >> 20);
          q   = 135135 * WONE + ((u * q) >> 20);
          num = (a * p) >> 20;
          t   = (num << 20) / q;
          if (t > WONE) t = WONE;
          return (t * TWO_OVER_PI) >> 20;
        end
        default: begin
          if (a > WONE) r = HALF_PI - atan_poly((64'd1 << 40) / a);
          else r = atan_poly(a);
          return (r * TWO_OVER_PI) >> 20;
        end
      endcase
    endfunction

    function void note_input(logic [SAMPLE_WIDTH-1:0] x);
      logic            neg;
      longint unsigned mag, m, lim;
      shaped_t         e;
      neg = x[SAMPLE_WIDTH-1];
      mag = neg ? (64'd1 << SAMPLE_WIDTH) - x : x;
      m   = curve(mag) * gain;
      m   = (m + 2048) >> 12;
      lim = neg ? (64'd1 << (SAMPLE_WIDTH - 1)) : (64'd1 << (SAMPLE_WIDTH - 1)) - 1;
      e.sat = m > lim;
      if (e.sat) m = lim;
      e.sample = neg ? SAMPLE_WIDTH'(-m) : SAMPLE_WIDTH'(m);
      pending.push_back(e);
    endfunction

    function void check_result(logic [SAMPLE_WIDTH-1:0] s, logic sat);
      shaped_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: sample_out=%h saturated=%b", s, sat);
        return;
      end
      e = pending.pop_front();
      if (e.sample !== s || e.sat !== sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected sample_out=%h saturated=%b, got %h %b",
                   e.sample, e.sat, s, sat);
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [SAMPLE_WIDTH-1:0] in_sample_in;
  logic                    out_valid;
  logic                    out_ready;
  logic [SAMPLE_WIDTH-1:0] out_sample_out;
  logic                    out_saturated;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [0:0]              cfg_index;
  logic [15:0]             cfg_data;

  shaper_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  audio_waveshape_clipper DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_sample_in);
      if (out_valid && out_ready) sb.check_result(out_sample_out, out_saturated);
    end
  end

  // Watchdog: count cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 6000) begin
      $display("audio_waveshape_clipper_test: FAIL");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off entirely while a long hold is counting
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        out_ready = 1'b0;
      end else begin
        out_ready = $urandom_range(99) >= recv_stall_pct;
      end
    end
  end

  // Drive one sample; returns at the falling edge after acceptance, valid still high
  task automatic send_sample(logic [SAMPLE_WIDTH-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_sample_in = x;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MODE) sb.mode = mode_t'(data[1:0]);
    else sb.gain = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
    logic [SAMPLE_WIDTH-1:0] x;
    case ($urandom_range(3))
      0, 1: x = SAMPLE_WIDTH'($urandom);
      2: x = SAMPLE_WIDTH'($urandom_range(2 * 1048576));
      default: x = SAMPLE_WIDTH'($urandom_range(5 * 1048576 + 8, 5 * 1048576 - 8));
    endcase
    if ($urandom_range(1)) x = -x;
    return x;
  endfunction

  logic [SAMPLE_WIDTH-1:0] corner[$] = '{
    24'd0, 24'd1, -24'sd1, 24'h7FFFFF, 24'h800000, 24'h800001,
    24'd1048576, -24'sd1048576, 24'd1048577, -24'sd1048577, 24'd1048575,
    24'd5242880, 24'd5242881, -24'sd5242881, 24'd524288, -24'sd3000000};

  initial begin
    logic [15:0] g;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_MODE;
    cfg_data     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed corners in the reset configuration (soft, unity gain)
    foreach (corner[i]) send_sample(corner[i]);

    for (int p = 0; p < 16; p++) begin
      drain();
      case (p / 4)
        0: g = 16'd4096;
        1: g = 16'hFFFF;
        2: g = (p == 8) ? 16'd0 : 16'd1;
        default: g = 16'($urandom);
      endcase
      write_reg(CFG_MODE, {14'($urandom), 2'(p)});
      write_reg(CFG_GAIN, g);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      // Long receiver hold-off while the sender keeps offering: fills the pipe
      if (p == 4) hold_cycles = 300;
      if (p < 4) foreach (corner[i]) send_sample(corner[i]);
      for (int n = 0; n < 120; n++) send_sample(rand_sample());
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0) $display("audio_waveshape_clipper_test: PASS");
    else $display("audio_waveshape_clipper_test: FAIL");
    $finish;
  end

endmodule
